// ===== sv/bmp_rle_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_rle_pkg
// Shared types, constants and helpers for the BMP pixel data decoder.
// ---------------------------------------------------------------------------
package bmp_rle_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;
  localparam int POS_MAX       = 8191;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // rle escape codes
  localparam logic [7:0] ESC_EOL   = 8'h00;
  localparam logic [7:0] ESC_EOP   = 8'h01;
  localparam logic [7:0] ESC_DELTA = 8'h02;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_TRUNC = 2'd2,
    ST_OOB   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_WIDTH      = 2'd0,
    REG_HEIGHT     = 2'd1,
    REG_DEPTH      = 2'd2,
    REG_COMPRESSED = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             depth8;
    logic             compressed;
  } cfg_t;

  typedef struct packed {
    status_t          kind;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [7:0]       len;
    logic [7:0]       first;
    logic [7:0]       second;
  } desc_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== sv/bmp_rle_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_rle_front
// Byte parser: tracks parse phase and pixel position, emits run and status descriptors.
// ---------------------------------------------------------------------------
module bmp_rle_front (
  input  logic                  clk,
  input  logic                  rst,
  input  bmp_rle_pkg::cfg_t     cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_data,
  input  logic                  q_full,
  output logic                  push,
  output bmp_rle_pkg::desc_t    push_data
);
  import bmp_rle_pkg::*;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_VALUE,
    PH_ESCAPE,
    PH_DELTA_X,
    PH_DELTA_Y,
    PH_ABS,
    PH_PAD
  } phase_t;

  function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
    logic [DIM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > (DIM_W+1)'(POS_MAX)) ? DIM_W'(POS_MAX) : s[DIM_W-1:0];
  endfunction

  phase_t           phase, phase_next;
  logic [DIM_W-1:0] column, column_next;
  logic [DIM_W-1:0] row, row_next;
  logic [7:0]       run_remaining, run_remaining_next;
  logic [11:0]      row_byte_count, row_byte_count_next;
  logic             pad_pending, pad_pending_next;
  logic             picture_done, picture_done_next;

  logic             accept;
  logic [DIM_W-1:0] wp3, wp7, rowbytes;
  logic [DIM_W-1:0] b13, c13, b_inc, row_inc, row_delta, col_tmp;
  logic [11:0]      b_new;
  logic [7:0]       hi, lo, abs_len;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    wp3      = cfg.width + DIM_W'(3);
    wp7      = cfg.width + DIM_W'(7);
    rowbytes = cfg.depth8 ? {wp3[DIM_W-1:2], 2'b00} : {1'b0, wp7[DIM_W-1:3], 2'b00};
    b13      = {1'b0, row_byte_count};
    c13      = {row_byte_count, 1'b0};
    b_inc    = b13 + DIM_W'(1);
    row_inc  = sat_add(row, DIM_W'(1));
    row_delta = sat_add(row, {5'b0, data_byte});
    hi       = cfg.depth8 ? data_byte : {4'b0, data_byte[7:4]};
    lo       = cfg.depth8 ? data_byte : {4'b0, data_byte[3:0]};
    if (cfg.depth8) begin
      abs_len = 8'd1;
    end else begin
      abs_len = (run_remaining >= 8'd2) ? 8'd2 : 8'd1;
    end
    if (abs_len > run_remaining) begin
      abs_len = run_remaining;
    end
    b_new   = '0;
    col_tmp = '0;

    phase_next          = phase;
    column_next         = column;
    row_next            = row;
    run_remaining_next  = run_remaining;
    row_byte_count_next = row_byte_count;
    pad_pending_next    = pad_pending;
    picture_done_next   = picture_done;
    push                = 1'b0;
    push_data           = '0;
    push_data.row       = row;

    if (accept) begin
      if (end_of_data) begin
        push                = 1'b1;
        push_data.kind      = picture_done ? ST_DONE : ST_TRUNC;
        phase_next          = PH_COUNT;
        column_next         = '0;
        row_next            = '0;
        run_remaining_next  = '0;
        row_byte_count_next = '0;
        pad_pending_next    = 1'b0;
        picture_done_next   = 1'b0;
      end else if (!picture_done) begin
        if (!cfg.compressed) begin
          // uncompressed padded rows
          if (cfg.depth8) begin
            if (b13 < cfg.width) begin
              push             = 1'b1;
              push_data.kind   = ST_RUN;
              push_data.col    = b13;
              push_data.len    = 8'd1;
              push_data.first  = data_byte;
              push_data.second = data_byte;
            end
          end else if (c13 < cfg.width) begin
            push             = 1'b1;
            push_data.kind   = ST_RUN;
            push_data.col    = c13;
            push_data.len    = ((c13 + DIM_W'(1)) < cfg.width) ? 8'd2 : 8'd1;
            push_data.first  = {4'b0, data_byte[7:4]};
            push_data.second = {4'b0, data_byte[3:0]};
          end
          if (b_inc >= rowbytes) begin
            b_new    = '0;
            row_next = row_inc;
            if (row_inc >= cfg.height) begin
              picture_done_next = 1'b1;
            end
          end else begin
            b_new = b_inc[11:0];
          end
          row_byte_count_next = b_new;
          column_next = cfg.depth8 ? {1'b0, b_new} : {b_new, 1'b0};
        end else begin
          case (phase)
            PH_COUNT: begin
              if (data_byte != ESC_EOL) begin
                run_remaining_next = data_byte;
                phase_next         = PH_VALUE;
              end else begin
                phase_next = PH_ESCAPE;
              end
            end
            PH_VALUE: begin
              push               = 1'b1;
              push_data.kind     = ST_RUN;
              push_data.col      = column;
              push_data.len      = run_remaining;
              push_data.first    = hi;
              push_data.second   = lo;
              column_next        = sat_add(column, {5'b0, run_remaining});
              run_remaining_next = '0;
              phase_next         = PH_COUNT;
            end
            PH_ESCAPE: begin
              phase_next = PH_COUNT;
              if (data_byte == ESC_EOL) begin
                column_next = '0;
                row_next    = row_inc;
                if (row_inc >= cfg.height) begin
                  picture_done_next = 1'b1;
                  push              = 1'b1;
                  push_data.kind    = ST_DONE;
                end
              end else if (data_byte == ESC_EOP) begin
                picture_done_next = 1'b1;
                push              = 1'b1;
                push_data.kind    = ST_DONE;
              end else if (data_byte == ESC_DELTA) begin
                phase_next = PH_DELTA_X;
              end else begin
                run_remaining_next = data_byte;
                if (cfg.depth8) begin
                  pad_pending_next = data_byte[0];
                end else begin
                  pad_pending_next = (data_byte[1:0] == 2'd1) || (data_byte[1:0] == 2'd2);
                end
                phase_next = PH_ABS;
              end
            end
            PH_DELTA_X: begin
              column_next = sat_add(column, {5'b0, data_byte});
              phase_next  = PH_DELTA_Y;
            end
            PH_DELTA_Y: begin
              row_next   = row_delta;
              phase_next = PH_COUNT;
              if (row_delta >= cfg.height) begin
                picture_done_next = 1'b1;
                push              = 1'b1;
                push_data.kind    = ST_DONE;
              end
            end
            PH_ABS: begin
              push               = 1'b1;
              push_data.kind     = ST_RUN;
              push_data.col      = column;
              push_data.len      = abs_len;
              push_data.first    = hi;
              push_data.second   = lo;
              col_tmp            = sat_add(column, {5'b0, abs_len});
              column_next        = col_tmp;
              run_remaining_next = run_remaining - abs_len;
              if (run_remaining == abs_len) begin
                phase_next       = pad_pending ? PH_PAD : PH_COUNT;
                pad_pending_next = 1'b0;
              end
            end
            default: begin
              phase_next = PH_COUNT;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_COUNT;
      column         <= '0;
      row            <= '0;
      run_remaining  <= '0;
      row_byte_count <= '0;
      pad_pending    <= 1'b0;
      picture_done   <= 1'b0;
    end else begin
      phase          <= phase_next;
      column         <= column_next;
      row            <= row_next;
      run_remaining  <= run_remaining_next;
      row_byte_count <= row_byte_count_next;
      pad_pending    <= pad_pending_next;
      picture_done   <= picture_done_next;
    end
  end

endmodule

// ===== sv/bmp_rle_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_rle_queue
// Small descriptor queue between the parser and the address stage.
// ---------------------------------------------------------------------------
module bmp_rle_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bmp_rle_pkg::desc_t push_data,
  output logic               full,
  input  logic               pop,
  output bmp_rle_pkg::desc_t pop_data,
  output logic               empty
);
  import bmp_rle_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/bmp_rle_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_rle_back
// Address stage: row offset multiply, then bounds check into output register.
// ---------------------------------------------------------------------------
module bmp_rle_back (
  input  logic               clk,
  input  logic               rst,
  input  bmp_rle_pkg::cfg_t  cfg,
  input  logic               q_empty,
  input  bmp_rle_pkg::desc_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        start_address,
  output logic [7:0]         run_length,
  output logic [7:0]         first_value,
  output logic [7:0]         second_value,
  output logic [1:0]         status
);
  import bmp_rle_pkg::*;

  logic             s1_valid, s1_load, s2_load;
  desc_t            s1_desc;
  logic             s1_row_oob;
  logic [23:0]      s1_prod;
  logic [24:0]      area;

  logic             row_oob;
  logic [DIM_W-1:0] span;
  logic [24:0]      prod_full, area_full, addr_sum, end_sum;

  assign s2_load = !out_valid || out_ready;
  assign s1_load = !s1_valid || s2_load;
  assign q_pop   = s1_load && !q_empty;

  always_comb begin
    row_oob   = (q_data.row >= cfg.height);
    span      = cfg.height - DIM_W'(1) - q_data.row;
    prod_full = {13'b0, span[11:0]} * {12'b0, cfg.width};
    area_full = {12'b0, cfg.width} * {12'b0, cfg.height};
    addr_sum  = {1'b0, s1_prod} + {12'b0, s1_desc.col};
    end_sum   = addr_sum + {17'b0, s1_desc.len};
  end

  always_ff @(posedge clk) begin
    area <= area_full;
    if (s1_load) begin
      s1_desc    <= q_data;
      s1_row_oob <= row_oob;
      s1_prod    <= prod_full[23:0];
    end
    if (s2_load) begin
      if (s1_desc.kind != ST_RUN) begin
        start_address <= '0;
        run_length    <= '0;
        first_value   <= '0;
        second_value  <= '0;
        status        <= s1_desc.kind;
      end else begin
        run_length   <= s1_desc.len;
        first_value  <= s1_desc.first;
        second_value <= s1_desc.second;
        if (s1_row_oob) begin
          start_address <= '0;
          status        <= ST_OOB;
        end else begin
          start_address <= addr_sum[23:0];
          status        <= (end_sum > area) ? ST_OOB : ST_RUN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= !q_empty;
      end
      if (s2_load) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

// ===== sv/bmp_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_rle_pixel_decoder
// BMP pixel data decoder (RLE8, RLE4 and uncompressed 4/8 bpp) to pixel runs.
// ---------------------------------------------------------------------------
// Takes one pixel data byte per clock and produces at most one run
// descriptor per byte. The parser updates its phase and position as each
// byte is accepted, so a new byte is accepted every cycle while the 4-entry
// descriptor queue has room. A descriptor is written into the queue, then
// passes the row offset multiplier into the stage-one register and the address
// add and bounds compare into the output register; output back-pressure can
// stall it. Configuration writes are taken every cycle and apply to the next
// byte; write them only while no transaction is outstanding.
// ---------------------------------------------------------------------------
module bmp_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] start_address,
  output logic [7:0]  run_length,
  output logic [7:0]  first_value,
  output logic [7:0]  second_value,
  output logic [1:0]  status
);
  import bmp_rle_pkg::*;

  logic [DIM_W-1:0] image_width, image_height;
  logic             pixel_depth, compressed;
  cfg_t             cfg;

  logic             q_push, q_full, q_pop, q_empty;
  desc_t            q_push_data, q_pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
      pixel_depth  <= 1'b1;
      compressed   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:      image_width  <= cfg_data;
        REG_HEIGHT:     image_height <= cfg_data;
        REG_DEPTH:      pixel_depth  <= cfg_data[0];
        REG_COMPRESSED: compressed   <= cfg_data[0];
        default:        image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    cfg.width      = clamp_dim(image_width);
    cfg.height     = clamp_dim(image_height);
    cfg.depth8     = pixel_depth;
    cfg.compressed = compressed;
  end

  bmp_rle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .q_full      (q_full),
    .push        (q_push),
    .push_data   (q_push_data)
  );

  bmp_rle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  bmp_rle_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .start_address (start_address),
    .run_length    (run_length),
    .first_value   (first_value),
    .second_value  (second_value),
    .status        (status)
  );

endmodule

// ===== sv/bmp_rle_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp_rle_chk
// Port-level checks for the BMP pixel data decoder.
// ---------------------------------------------------------------------------
module bmp_rle_chk (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [12:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic        end_of_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] start_address,
  input logic [7:0]  run_length,
  input logic [7:0]  first_value,
  input logic [7:0]  second_value,
  input logic [1:0]  status
);
  import bmp_rle_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(start_address) &&
      $stable(run_length) && $stable(first_value) && $stable(second_value) &&
      $stable(status))
    else $error("output transaction changed while stalled");

  // completion and truncation carry no run
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DONE || status == ST_TRUNC) |->
      start_address == '0 && run_length == '0 && first_value == '0 &&
      second_value == '0)
    else $error("end status with nonzero run fields");

  // nothing pending after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output valid or input stalled after reset");

endmodule

bind bmp_rle_pixel_decoder bmp_rle_chk u_chk (.*);
